@@ src/crcfr_pkg.sv @@
// Shared constants and types for the CRC-16 frame receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package crcfr_pkg;

    // Result event codes
    localparam logic [2:0] EV_BUSY      = 3'd0;
    localparam logic [2:0] EV_OK        = 3'd1;
    localparam logic [2:0] EV_BAD_START = 3'd2;
    localparam logic [2:0] EV_BAD_END   = 3'd3;
    localparam logic [2:0] EV_BAD_CRC   = 3'd4;

    // Frame position codes
    localparam logic [3:0] IDX_HUNT     = 4'd0;
    localparam logic [3:0] IDX_PAY_LAST = 4'd6;
    localparam logic [3:0] IDX_CRC_HI   = 4'd7;
    localparam logic [3:0] IDX_CRC_LO   = 4'd8;
    localparam logic [3:0] IDX_END      = 4'd9;
    localparam logic [3:0] FRAME_LEN    = 4'd10;

    localparam int PAYLOAD_LEN = 6;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Register map
    localparam logic REG_START = 1'b0;
    localparam logic REG_END   = 1'b1;

    localparam logic [7:0] START_RESET = 8'h23;
    localparam logic [7:0] END_RESET   = 8'h0D;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
    } t_cfg;

endpackage

`default_nettype wire

@@ src/crcfr_crc_byte.sv @@
// One-byte update of CRC-16/CCITT-FALSE, MSB first, purely combinational.
// Depends on crcfr_pkg for the polynomial.
`default_nettype none

module crcfr_crc_byte
    import crcfr_pkg::*;
(
    input  wire logic [15:0] i_crc,
    input  wire logic [7:0]  i_data,
    output logic      [15:0] o_crc
);

    always_comb begin
        logic [15:0] acc;
        acc = i_crc ^ {i_data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (acc[15]) begin
                acc = {acc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                acc = {acc[14:0], 1'b0};
            end
        end
        o_crc = acc;
    end

endmodule

`default_nettype wire

@@ src/crcfr_regs.sv @@
// APB-style configuration registers: start and end marker bytes.
// Depends on crcfr_pkg for the register map and reset values.
`default_nettype none

module crcfr_regs
    import crcfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    // register index is the word address; byte offset bits are ignored
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte <= START_RESET;
            r_cfg.end_byte   <= END_RESET;
        end else if (w_wr) begin
            case (paddr[2])
                REG_START: r_cfg.start_byte <= pwdata[7:0];
                REG_END:   r_cfg.end_byte   <= pwdata[7:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_START: prdata = {24'h000000, r_cfg.start_byte};
            REG_END:   prdata = {24'h000000, r_cfg.end_byte};
            default:   prdata = 32'h00000000;
        endcase
    end

endmodule

`default_nettype wire

@@ src/crc16_frame_receiver.sv @@
// Top level of the CRC-16 frame receiver: frame tracking, payload capture,
// error counting and the result register. Uses crcfr_pkg, crcfr_crc_byte, crcfr_regs.
`default_nettype none

// Receives one byte per clock while o_in_ready is high and reports one result per
// byte. A frame is start, six payload bytes, CRC high, CRC low, end; the
// CRC-16/CCITT-FALSE covers start and payload. Each byte's CRC step, index update
// and checks are combinational, so a byte can be accepted whenever o_in_ready is
// high; its result appears in the output register in the cycle after acceptance.
// The output register is the only buffer: o_in_ready is low only while a result is
// held and i_out_ready is low. Payload outputs are zero unless the event is
// "frame ok"; o_error_count saturates at 0xFFFF. The user must set markers via APB
// (start at 0x0, end at 0x4) while no byte is in flight; the block does not check.
module crc16_frame_receiver
    import crcfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte input
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_gap_before,
    // result output
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [2:0]  o_event_res,
    output logic      [7:0]  o_device_id,
    output logic      [7:0]  o_frame_status,
    output logic      [7:0]  o_command,
    output logic      [7:0]  o_key_byte,
    output logic      [7:0]  o_value_high,
    output logic      [7:0]  o_value_low,
    output logic      [15:0] o_error_count,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    t_cfg w_cfg;

    logic [3:0]  r_idx;
    logic [15:0] r_crc;
    logic [15:0] r_err;
    logic [7:0]  r_payload [PAYLOAD_LEN];
    logic [7:0]  r_crc_hi;
    logic [7:0]  r_crc_lo;

    logic        r_out_valid;
    logic [2:0]  r_ev;
    logic [7:0]  r_out_pay [PAYLOAD_LEN];
    logic [15:0] r_out_err;

    logic        w_acc;
    logic        w_hunt;
    logic [3:0]  w_eff_idx;
    logic [15:0] w_crc_in;
    logic [15:0] w_crc_out;
    logic [2:0]  w_pay_ptr;

    logic [3:0]  n_idx;
    logic [15:0] n_crc;
    logic [15:0] n_err;
    logic [2:0]  n_ev;
    logic        n_err_inc;
    logic        n_pay_we;
    logic        n_hi_we;
    logic        n_lo_we;

    crcfr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    crcfr_crc_byte u_crc (
        .i_crc  (w_crc_in),
        .i_data (i_rx_byte),
        .o_crc  (w_crc_out)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_acc      = i_in_valid && o_in_ready;

    // a gap inside a frame, or a stray index, restarts the hunt on this byte
    assign w_hunt    = (r_idx >= FRAME_LEN) || (i_gap_before && (r_idx != IDX_HUNT));
    assign w_eff_idx = w_hunt ? IDX_HUNT : r_idx;
    assign w_crc_in  = (w_eff_idx == IDX_HUNT) ? CRC_INIT : r_crc;
    assign w_pay_ptr = w_eff_idx[2:0] - 3'd1;

    always_comb begin
        n_idx     = w_eff_idx;
        n_crc     = w_hunt ? CRC_INIT : r_crc;
        n_ev      = EV_BUSY;
        n_err_inc = 1'b0;
        n_pay_we  = 1'b0;
        n_hi_we   = 1'b0;
        n_lo_we   = 1'b0;
        case (w_eff_idx)
            IDX_HUNT: begin
                if (i_rx_byte != w_cfg.start_byte) begin
                    n_err_inc = 1'b1;
                    n_ev      = EV_BAD_START;
                end else begin
                    n_crc = w_crc_out;
                    n_idx = 4'd1;
                end
            end
            IDX_CRC_HI: begin
                n_hi_we = 1'b1;
                n_idx   = IDX_CRC_LO;
            end
            IDX_CRC_LO: begin
                n_lo_we = 1'b1;
                n_idx   = IDX_END;
            end
            IDX_END: begin
                // end marker is checked ahead of the CRC
                if (i_rx_byte != w_cfg.end_byte) begin
                    n_err_inc = 1'b1;
                    n_ev      = EV_BAD_END;
                end else if ({r_crc_hi, r_crc_lo} != r_crc) begin
                    n_err_inc = 1'b1;
                    n_ev      = EV_BAD_CRC;
                end else begin
                    n_ev = EV_OK;
                end
                n_idx = IDX_HUNT;
                n_crc = CRC_INIT;
            end
            default: begin
                // payload bytes 1..6
                n_pay_we = 1'b1;
                n_crc    = w_crc_out;
                n_idx    = w_eff_idx + 4'd1;
            end
        endcase
        n_err = (n_err_inc && (r_err != 16'hFFFF)) ? r_err + 16'd1 : r_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= IDX_HUNT;
            r_crc       <= CRC_INIT;
            r_err       <= 16'h0000;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_idx       <= n_idx;
                r_crc       <= n_crc;
                r_err       <= n_err;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            if (n_pay_we) begin
                r_payload[w_pay_ptr] <= i_rx_byte;
            end
            if (n_hi_we) begin
                r_crc_hi <= i_rx_byte;
            end
            if (n_lo_we) begin
                r_crc_lo <= i_rx_byte;
            end
            r_ev      <= n_ev;
            r_out_err <= n_err;
            for (int j = 0; j < PAYLOAD_LEN; j++) begin
                r_out_pay[j] <= (n_ev == EV_OK) ? r_payload[j] : 8'h00;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_res    = r_ev;
    assign o_device_id    = r_out_pay[0];
    assign o_frame_status = r_out_pay[1];
    assign o_command      = r_out_pay[2];
    assign o_key_byte     = r_out_pay[3];
    assign o_value_high   = r_out_pay[4];
    assign o_value_low    = r_out_pay[5];
    assign o_error_count  = r_out_err;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_END)
        else $error("frame index out of range");

    a_err_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_err >= $past(r_err))
        else $error("error count went down");

    a_gap_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_gap_before) |=> (r_idx <= 4'd1))
        else $error("gap did not restart the hunt");

    a_pay_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_ev != EV_OK)) |->
            ({r_out_pay[0], r_out_pay[1], r_out_pay[2],
              r_out_pay[3], r_out_pay[4], r_out_pay[5]} == 48'h0))
        else $error("payload not cleared on a failed result");
`endif

endmodule

`default_nettype wire
